// ----- rtl/sra_pkg.sv -----
// Shared types and constants for the selective-repeat ARQ controller.
// Used by every module under rtl/; depends on nothing.
`default_nettype none
package sra_pkg;

   localparam int unsigned SeqW  = 5;
   localparam int unsigned SlotW = 4;
   localparam int unsigned LenW  = 9;
   localparam logic [SeqW-1:0] MaxSeqNum   = 5'd31;
   localparam logic [SeqW-1:0] WindowSlots = 5'd16;
   localparam logic [LenW-1:0] HeaderLen   = 9'd7;

   typedef logic [SeqW-1:0]  seq_type;
   typedef logic [SlotW-1:0] slot_type;
   typedef logic [LenW-1:0]  len_type;

   // Classified event kinds.
   typedef enum logic [2:0] {
      EV_PKT_READY  = 3'd0,
      EV_PHY_READY  = 3'd1,
      EV_FRAME_RX   = 3'd2,
      EV_DATA_TMO   = 3'd3,
      EV_ACK_TMO    = 3'd4,
      EV_NONE       = 3'd5
   } ev_type;

   localparam logic [1:0] KindData = 2'd0;
   localparam logic [1:0] KindAck  = 2'd1;
   localparam logic [1:0] KindNak  = 2'd2;

   typedef enum logic [2:0] {
      ACT_DATA    = 3'd0,
      ACT_ACK     = 3'd1,
      ACT_NAK     = 3'd2,
      ACT_DELIVER = 3'd3,
      ACT_ACKTMR  = 3'd4,
      ACT_STOP    = 3'd5,
      ACT_STATUS  = 3'd6
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_HEAD, ST_DELIV, ST_ACKTMR, ST_STOP, ST_STATUS
   } eng_state_type;

   typedef struct packed {
      ev_type     ev;
      logic       good;
      logic [1:0] kind;
      seq_type    rseq;
      seq_type    rack;
      len_type    rlen;
      slot_type   tslot;
   } evt_type;

   typedef struct packed {
      act_type  action;
      seq_type  tx_seq;
      seq_type  tx_ack;
      slot_type buffer_slot;
      len_type  payload_length;
      logic     net_enable;
      logic     last;
   } rsp_type;

   function automatic logic in_range(seq_type a, seq_type b, seq_type c);
      return (a <= b && b < c) || (c < a && b < c) || (c < a && a <= b);
   endfunction

   function automatic seq_type seq_inc(seq_type k);
      return (k == MaxSeqNum) ? '0 : k + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sra_front.sv -----
// Front end: accepts request events, classifies them, holds them in a
// two-entry queue for the engine. Depends on sra_pkg.
`default_nettype none
module sra_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic [2:0]      req_type,
   input  wire logic            req_frame_good,
   input  wire logic [1:0]      req_rx_kind,
   input  wire sra_pkg::seq_type  req_rx_seq,
   input  wire sra_pkg::seq_type  req_rx_ack,
   input  wire sra_pkg::len_type  req_rx_length,
   input  wire sra_pkg::slot_type req_timeout_slot,
   output logic                 evt_valid,
   output sra_pkg::evt_type     evt,
   input  wire logic            evt_pop
);
   sra_pkg::evt_type q_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   sra_pkg::evt_type cls;
   logic             do_push, do_pop;

   always_comb begin
      unique case (req_type)
         3'd0:    cls.ev = sra_pkg::EV_PKT_READY;
         3'd1:    cls.ev = sra_pkg::EV_PHY_READY;
         3'd2:    cls.ev = sra_pkg::EV_FRAME_RX;
         3'd3:    cls.ev = sra_pkg::EV_DATA_TMO;
         3'd4:    cls.ev = sra_pkg::EV_ACK_TMO;
         default: cls.ev = sra_pkg::EV_NONE;
      endcase
      cls.good  = req_frame_good;
      cls.kind  = req_rx_kind;
      cls.rseq  = req_rx_seq;
      cls.rack  = req_rx_ack;
      cls.rlen  = req_rx_length;
      cls.tslot = req_timeout_slot;
   end

   assign full      = (cnt_ff == 2'd2);
   assign evt_valid = (cnt_ff != 2'd0);
   assign evt       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = evt_pop && evt_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 2'd1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule
`default_nettype wire

// ----- rtl/sra_engine.sv -----
// Back end: window state and the action sequencer, at most one result per cycle while the result queue has room.
// Depends on sra_pkg.
`default_nettype none
module sra_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             evt_valid,
   input  wire sra_pkg::evt_type evt,
   output logic                  evt_pop,
   output logic                  out_push,
   output sra_pkg::rsp_type      out_item,
   input  wire logic             out_full
);
   sra_pkg::eng_state_type state_ff, state_in;
   sra_pkg::evt_type  evt_ff, evt_in;
   sra_pkg::seq_type  nts_ff, nts_in, old_ff, old_in, exp_ff, exp_in;
   sra_pkg::seq_type  upr_ff, upr_in, outs_ff, outs_in;
   logic [(1 << sra_pkg::SlotW)-1:0] arr_ff, arr_in;
   logic              nak_ok_ff, nak_ok_in, phys_ff, phys_in;
   logic              restart_ff, restart_in;
   sra_pkg::len_type  plen_ff, plen_in;
   logic [sra_pkg::SeqW-1:0] k_ff, k_in;
   sra_pkg::seq_type  nseq, tseq, piggy;
   logic              go;

   assign piggy = exp_ff - 1'b1;
   assign go    = !out_full;
   assign nseq  = sra_pkg::seq_inc(evt_ff.rack);
   assign tseq  = sra_pkg::in_range(old_ff, {1'b0, evt_ff.tslot}, nts_ff)
                  ? {1'b0, evt_ff.tslot} : {1'b1, evt_ff.tslot};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sra_pkg::ST_IDLE;
         nts_ff    <= '0;
         old_ff    <= '0;
         exp_ff    <= '0;
         upr_ff    <= sra_pkg::WindowSlots;
         outs_ff   <= '0;
         arr_ff    <= '0;
         nak_ok_ff <= 1'b1;
         phys_ff   <= 1'b0;
         restart_ff <= 1'b0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         nts_ff    <= nts_in;
         old_ff    <= old_in;
         exp_ff    <= exp_in;
         upr_ff    <= upr_in;
         outs_ff   <= outs_in;
         arr_ff    <= arr_in;
         nak_ok_ff <= nak_ok_in;
         phys_ff   <= phys_in;
         restart_ff <= restart_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff  <= evt_in;
      plen_ff <= plen_in;
   end

   always_comb begin
      state_in   = state_ff;
      evt_in     = evt_ff;
      nts_in     = nts_ff;
      old_in     = old_ff;
      exp_in     = exp_ff;
      upr_in     = upr_ff;
      outs_in    = outs_ff;
      arr_in     = arr_ff;
      nak_ok_in  = nak_ok_ff;
      phys_in    = phys_ff;
      restart_in = restart_ff;
      plen_in    = plen_ff;
      k_in       = k_ff;
      evt_pop    = 1'b0;
      out_push   = 1'b0;
      out_item   = '0;
      unique case (state_ff)
         sra_pkg::ST_IDLE: begin
            if (evt_valid) begin
               evt_pop  = 1'b1;
               evt_in   = evt;
               state_in = sra_pkg::ST_HEAD;
            end
         end
         sra_pkg::ST_HEAD: begin
            if (go) begin
               state_in = sra_pkg::ST_STATUS;
               k_in     = '0;
               unique case (evt_ff.ev)
                  sra_pkg::EV_PKT_READY: begin
                     out_push = 1'b1;
                     out_item.action      = sra_pkg::ACT_DATA;
                     out_item.tx_seq      = nts_ff;
                     out_item.tx_ack      = piggy;
                     out_item.buffer_slot = nts_ff[sra_pkg::SlotW-1:0];
                     outs_in = outs_ff + 1'b1;
                     nts_in  = sra_pkg::seq_inc(nts_ff);
                     phys_in = 1'b0;
                  end
                  sra_pkg::EV_PHY_READY: phys_in = 1'b1;
                  sra_pkg::EV_FRAME_RX: begin
                     if (!evt_ff.good) begin
                        if (nak_ok_ff) begin
                           out_push = 1'b1;
                           out_item.action = sra_pkg::ACT_NAK;
                           out_item.tx_ack = piggy;
                           nak_ok_in = 1'b0;
                           phys_in   = 1'b0;
                        end
                     end else if (evt_ff.kind == sra_pkg::KindData) begin
                        if (evt_ff.rseq != exp_ff && nak_ok_ff) begin
                           out_push = 1'b1;
                           out_item.action = sra_pkg::ACT_NAK;
                           out_item.tx_ack = piggy;
                           nak_ok_in = 1'b0;
                           phys_in   = 1'b0;
                        end else begin
                           restart_in = (evt_ff.rseq == exp_ff);
                           if (sra_pkg::in_range(exp_ff, evt_ff.rseq, upr_ff) &&
                               !arr_ff[evt_ff.rseq[sra_pkg::SlotW-1:0]]) begin
                              arr_in[evt_ff.rseq[sra_pkg::SlotW-1:0]] = 1'b1;
                              plen_in  = (evt_ff.rlen >= sra_pkg::HeaderLen)
                                         ? evt_ff.rlen - sra_pkg::HeaderLen : '0;
                              state_in = sra_pkg::ST_DELIV;
                           end else begin
                              state_in = sra_pkg::ST_ACKTMR;
                           end
                        end
                     end else begin
                        if (evt_ff.kind == sra_pkg::KindNak &&
                            sra_pkg::in_range(old_ff, nseq, nts_ff)) begin
                           out_push = 1'b1;
                           out_item.action      = sra_pkg::ACT_DATA;
                           out_item.tx_seq      = nseq;
                           out_item.tx_ack      = piggy;
                           out_item.buffer_slot = nseq[sra_pkg::SlotW-1:0];
                           phys_in = 1'b0;
                        end
                        state_in = sra_pkg::ST_STOP;
                     end
                  end
                  sra_pkg::EV_DATA_TMO: begin
                     out_push = 1'b1;
                     out_item.action      = sra_pkg::ACT_DATA;
                     out_item.tx_seq      = tseq;
                     out_item.tx_ack      = piggy;
                     out_item.buffer_slot = evt_ff.tslot;
                     phys_in = 1'b0;
                  end
                  sra_pkg::EV_ACK_TMO: begin
                     out_push = 1'b1;
                     out_item.action = sra_pkg::ACT_ACK;
                     out_item.tx_ack = piggy;
                     phys_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         sra_pkg::ST_DELIV: begin
            if (go) begin
               if (arr_ff[exp_ff[sra_pkg::SlotW-1:0]]) begin
                  out_push = 1'b1;
                  out_item.action         = sra_pkg::ACT_DELIVER;
                  out_item.buffer_slot    = exp_ff[sra_pkg::SlotW-1:0];
                  out_item.payload_length = plen_ff;
                  arr_in[exp_ff[sra_pkg::SlotW-1:0]] = 1'b0;
                  nak_ok_in  = 1'b1;
                  exp_in     = sra_pkg::seq_inc(exp_ff);
                  upr_in     = sra_pkg::seq_inc(upr_ff);
                  restart_in = 1'b1;
               end else begin
                  state_in = sra_pkg::ST_ACKTMR;
               end
            end
         end
         sra_pkg::ST_ACKTMR: begin
            if (go) begin
               if (restart_ff) begin
                  out_push = 1'b1;
                  out_item.action = sra_pkg::ACT_ACKTMR;
               end
               k_in     = '0;
               state_in = sra_pkg::ST_STOP;
            end
         end
         sra_pkg::ST_STOP: begin
            if (go) begin
               if (k_ff < sra_pkg::WindowSlots &&
                   sra_pkg::in_range(old_ff, evt_ff.rack, nts_ff)) begin
                  out_push = 1'b1;
                  out_item.action      = sra_pkg::ACT_STOP;
                  out_item.buffer_slot = old_ff[sra_pkg::SlotW-1:0];
                  outs_in = outs_ff - 1'b1;
                  old_in  = sra_pkg::seq_inc(old_ff);
                  k_in    = k_ff + 1'b1;
               end else begin
                  state_in = sra_pkg::ST_STATUS;
               end
            end
         end
         sra_pkg::ST_STATUS: begin
            if (go) begin
               out_push = 1'b1;
               out_item.action     = sra_pkg::ACT_STATUS;
               out_item.net_enable = (outs_ff < sra_pkg::WindowSlots) && phys_ff;
               out_item.last       = 1'b1;
               state_in = sra_pkg::ST_IDLE;
            end
         end
         default: state_in = sra_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/sra_rsp_fifo.sv -----
// Result queue between the engine and the result ports.
// Depends on sra_pkg.
`default_nettype none
module sra_rsp_fifo #(
   parameter int unsigned DEPTH_LOG2 = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_push,
   input  wire sra_pkg::rsp_type in_item,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output sra_pkg::rsp_type      out_item
);
   localparam int unsigned Depth = 1 << DEPTH_LOG2;
   sra_pkg::rsp_type     mem_ff [Depth];
   logic [DEPTH_LOG2-1:0] wr_ff, rd_ff;
   logic [DEPTH_LOG2:0]   cnt_ff;
   logic                  do_push, do_pop;

   assign full     = (cnt_ff == (DEPTH_LOG2+1)'(Depth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = in_push && !full;
   assign do_pop   = pop && !empty;
   assign out_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (!do_push && do_pop) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ----- rtl/selective_repeat_arq_controller_core.sv -----
// An event passes the front queue and the engine's event register before its first
// result can be queued; results follow at most one a cycle while the result queue has
// room. Each event yields 1..34 results, the last a status result, before the engine
// takes the next. Silent sequencer steps can come between (a head step with no send, a
// skipped ack-timer restart, the exits of the delivery and timer-stop loops). Reset
// (sync, active high) empties both queues and resets the window state at once.
`default_nettype none
module selective_repeat_arq_controller_core #(
   parameter int unsigned RSP_DEPTH_LOG2 = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request queue side
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_type,
   input  wire logic        req_frame_good,
   input  wire logic [1:0]  req_rx_kind,
   input  wire logic [4:0]  req_rx_seq,
   input  wire logic [4:0]  req_rx_ack,
   input  wire logic [8:0]  req_rx_length,
   input  wire logic [3:0]  req_timeout_slot,
   // response queue side
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_action,
   output logic [4:0]       rsp_tx_seq,
   output logic [4:0]       rsp_tx_ack,
   output logic [3:0]       rsp_buffer_slot,
   output logic [8:0]       rsp_payload_length,
   output logic             rsp_net_enable,
   output logic             rsp_last
);
   sra_pkg::evt_type evt;
   sra_pkg::rsp_type eng_item, head_item;
   logic             evt_valid, evt_pop, eng_push, rsp_full;

   // Classify each transfer and hold it until the engine takes it.
   sra_front u_front (
      .clock, .reset, .push, .full,
      .req_type, .req_frame_good, .req_rx_kind, .req_rx_seq, .req_rx_ack,
      .req_rx_length, .req_timeout_slot,
      .evt_valid, .evt, .evt_pop
   );

   // Run the window bookkeeping; hold each result step while the result queue is full.
   sra_engine u_engine (
      .clock, .reset, .evt_valid, .evt, .evt_pop,
      .out_push(eng_push), .out_item(eng_item), .out_full(rsp_full)
   );

   // Decouple the consumer from the engine.
   sra_rsp_fifo #(.DEPTH_LOG2(RSP_DEPTH_LOG2)) u_rsp_fifo (
      .clock, .reset, .in_push(eng_push), .in_item(eng_item),
      .full(rsp_full), .empty, .pop, .out_item(head_item)
   );

   assign rsp_action         = head_item.action;
   assign rsp_tx_seq         = head_item.tx_seq;
   assign rsp_tx_ack         = head_item.tx_ack;
   assign rsp_buffer_slot    = head_item.buffer_slot;
   assign rsp_payload_length = head_item.payload_length;
   assign rsp_net_enable     = head_item.net_enable;
   assign rsp_last           = head_item.last;
endmodule
`default_nettype wire

// ----- rtl/sra_checker.sv -----
// Port-level checks for the ARQ controller core and their bind.
// Depends on sra_pkg and selective_repeat_arq_controller_core.
`default_nettype none
module sra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       empty,
   input wire logic [2:0] rsp_action,
   input wire logic [4:0] rsp_tx_seq,
   input wire logic [4:0] rsp_tx_ack,
   input wire logic       rsp_net_enable,
   input wire logic       rsp_last
);
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");
   a_last_status: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_last |-> rsp_action == sra_pkg::ACT_STATUS)
      else $error("last set on non-status result");
   a_ne_status: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_action != sra_pkg::ACT_STATUS |-> !rsp_net_enable && !rsp_last)
      else $error("status fields on non-status result");
   a_deliver_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_action == sra_pkg::ACT_DELIVER |-> rsp_tx_seq == '0 && rsp_tx_ack == '0)
      else $error("deliver carries frame numbers");
endmodule

bind selective_repeat_arq_controller_core sra_checker u_sra_checker (
   .clock, .reset, .empty, .rsp_action, .rsp_tx_seq, .rsp_tx_ack,
   .rsp_net_enable, .rsp_last
);
`default_nettype wire
